@@ design/flic_pkg.sv @@
// shared types and codes of the free list insert and coalesce core
// no dependencies; used by the cell row, the top level and the checker
`default_nettype none

package flic_pkg;

    // payload size width, fixed by the stream format
    localparam int LEN_W = 32;

    // result status codes
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_NEXT     = 3'd1;
    localparam logic [2:0] ST_PREV     = 3'd2;
    localparam logic [2:0] ST_BOTH     = 3'd3;
    localparam logic [2:0] ST_NULL     = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    // update commands broadcast to the cell row
    localparam logic [2:0] OP_HOLD = 3'd0;
    localparam logic [2:0] OP_INS  = 3'd1;
    localparam logic [2:0] OP_PREV = 3'd2;
    localparam logic [2:0] OP_NEXT = 3'd3;
    localparam logic [2:0] OP_BOTH = 3'd4;

    // output beat layout
    localparam int OUT_W = 80;

    typedef struct packed {
        logic       cmp;
        logic [2:0] op;
    } ctrl_t;

    typedef struct packed {
        logic le;
        logic prev_sel;
        logic prev_hit;
        logic next_sel;
        logic next_hit;
    } flags_t;

endpackage

`default_nettype wire

@@ design/flic_cell.sv @@
// one cell of the sorted extent row: holds one extent, compares and shifts
// depends on flic_pkg
`default_nettype none

module flic_cell #(
    parameter int ADDR_BITS = 32,
    localparam int SUM_W = ((ADDR_BITS > flic_pkg::LEN_W) ? ADDR_BITS : flic_pkg::LEN_W) + 2
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  flic_pkg::ctrl_t              ctrl,
    input  wire                          valid,
    input  wire                          le_left,
    input  wire                          le_right,
    input  wire [ADDR_BITS-1:0]          addr,
    input  wire [SUM_W-1:0]              end_new,
    input  wire [7:0]                    hdr,
    input  wire [flic_pkg::LEN_W-1:0]    new_len,
    input  wire [ADDR_BITS-1:0]          left_start,
    input  wire [flic_pkg::LEN_W-1:0]    left_len,
    input  wire [ADDR_BITS-1:0]          right_start,
    input  wire [flic_pkg::LEN_W-1:0]    right_len,
    output flic_pkg::flags_t             flags,
    output logic [ADDR_BITS-1:0]         start,
    output logic [flic_pkg::LEN_W-1:0]   len
);

    logic [ADDR_BITS-1:0]       start_reg;
    logic [flic_pkg::LEN_W-1:0] len_reg;
    logic [ADDR_BITS-1:0]       start_next;
    logic [flic_pkg::LEN_W-1:0] len_next;
    logic                       prev_role_reg, next_role_reg, ins_role_reg, after_role_reg;
    logic                       le, prev_c, next_c, ins_c;
    logic [SUM_W-1:0]           prev_end;

    always_comb
    begin
        le       = valid && (start_reg <= addr);
        prev_c   = le && !le_right;
        next_c   = valid && !le && le_left;
        ins_c    = !le && le_left;
        prev_end = SUM_W'(start_reg) + SUM_W'(len_reg) + SUM_W'(hdr);

        flags.le       = le;
        flags.prev_sel = prev_c;
        flags.prev_hit = prev_c && (prev_end == SUM_W'(addr));
        flags.next_sel = next_c;
        flags.next_hit = next_c && (end_new == SUM_W'(start_reg));
    end

    // roles latched in the compare cycle, used in the update cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_role_reg  <= 1'b0;
            next_role_reg  <= 1'b0;
            ins_role_reg   <= 1'b0;
            after_role_reg <= 1'b0;
        end
        else if (ctrl.cmp)
        begin
            prev_role_reg  <= prev_c;
            next_role_reg  <= next_c;
            ins_role_reg   <= ins_c;
            after_role_reg <= !le;
        end
    end

    always_comb
    begin
        start_next = start_reg;
        len_next   = len_reg;
        case (ctrl.op)
            flic_pkg::OP_BOTH:
            begin
                if (prev_role_reg)
                begin
                    len_next = new_len;
                end
                else if (after_role_reg)
                begin
                    start_next = right_start;
                    len_next   = right_len;
                end
            end
            flic_pkg::OP_PREV:
            begin
                if (prev_role_reg)
                begin
                    len_next = new_len;
                end
            end
            flic_pkg::OP_NEXT:
            begin
                if (next_role_reg)
                begin
                    start_next = addr;
                    len_next   = new_len;
                end
            end
            flic_pkg::OP_INS:
            begin
                if (ins_role_reg)
                begin
                    start_next = addr;
                    len_next   = new_len;
                end
                else if (after_role_reg)
                begin
                    start_next = left_start;
                    len_next   = left_len;
                end
            end
            default:
            begin
                start_next = start_reg;
                len_next   = len_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        len_reg   <= len_next;
    end

    assign start = start_reg;
    assign len   = len_reg;

endmodule

`default_nettype wire

@@ design/free_list_insert_coalesce_core.sv @@
// a beat passes capture, compare and update before its result beat is registered
// a new beat is taken only while idle or in the update cycle, so compare and update alternate on the cell row
// the update waits while an earlier result beat is still held on the master side
// reset: asynchronous active low; table empty, header_bytes = 16, no result pending
// extent storage in the cells is not cleared; entries past the count are never used
// top level of the free list core; depends on flic_pkg and flic_cell
`default_nettype none

module free_list_insert_coalesce_core #(
    parameter int ENTRIES   = 32,
    parameter int ADDR_BITS = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    // input beats
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // block_addr[31:0], block_size[63:32]
    // result beats
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [79:0] m_tdata,   // status[2:0], extent_addr[34:3], extent_size[66:35],
                                   // entry_count[72:67], zero[79:73]
    // register port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LEN_W   = flic_pkg::LEN_W;
    localparam int SUM_W   = ((ADDR_BITS > LEN_W) ? ADDR_BITS : LEN_W) + 2;
    localparam int COUNT_W = $clog2(ENTRIES + 1);
    localparam int MSUM_W  = LEN_W + 3;

    // register map: word index taken from paddr[2]
    localparam logic REG_HEADER = 1'b0;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [7:0]           hdr_reg;
    logic [COUNT_W-1:0]   n_reg, n_next;

    // captured beat
    logic [ADDR_BITS-1:0] addr_reg;
    logic [LEN_W-1:0]     size_reg;

    // compare results
    logic [2:0]           op_reg, op_next;
    logic [2:0]           status_reg, status_next;
    logic [ADDR_BITS-1:0] prev_start_reg, prev_start_next;
    logic [LEN_W-1:0]     prev_len_reg, prev_len_next;
    logic [LEN_W-1:0]     next_len_reg, next_len_next;

    // result beat holding register
    logic                 m_tvalid_reg;
    logic [79:0]          m_tdata_reg;

    logic                 in_beat, out_free, commit;
    logic                 any_prev_hit, any_next_hit;
    logic [SUM_W-1:0]     end_new;
    logic [MSUM_W-1:0]    merge_sum;
    logic [LEN_W-1:0]     new_len;
    logic [LEN_W-1:0]     res_size;
    logic [ADDR_BITS-1:0] res_addr;
    logic                 add_prev, add_next;
    flic_pkg::ctrl_t      ctrl;

    flic_pkg::flags_t     flags   [ENTRIES];
    logic [ADDR_BITS-1:0] c_start [ENTRIES];
    logic [LEN_W-1:0]     c_len   [ENTRIES];

    // ------------------------------------------------------------------
    // register port: single header_bytes register, no wait states
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HEADER) ? {24'd0, hdr_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg <= 8'd16;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_HEADER))
        begin
            hdr_reg <= pwdata[7:0];
        end
    end

    // ------------------------------------------------------------------
    // handshake and sequencing
    // a new beat is taken when idle, or in the update cycle once the
    // result register is free, so compare and update alternate
    // ------------------------------------------------------------------
    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = (state_reg == S_UPD) && out_free;
    assign s_tready = (state_reg == S_IDLE) || commit;
    assign in_beat  = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (commit)
                begin
                    state_next = in_beat ? S_CMP : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // beat capture; the address is cut or widened to the table's width
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            addr_reg <= ADDR_BITS'(s_tdata[31:0]);
            size_reg <= s_tdata[63:32];
        end
    end

    // ------------------------------------------------------------------
    // cell row: every cell compares its extent with the new block in the
    // compare cycle, then shifts or rewrites itself in the update cycle
    // ------------------------------------------------------------------
    assign end_new   = SUM_W'(addr_reg) + SUM_W'(size_reg) + SUM_W'(hdr_reg);
    assign ctrl.cmp  = (state_reg == S_CMP);
    assign ctrl.op   = commit ? op_reg : flic_pkg::OP_HOLD;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        logic                 valid;
        logic                 le_left;
        logic                 le_right;
        logic [ADDR_BITS-1:0] left_start;
        logic [LEN_W-1:0]     left_len;
        logic [ADDR_BITS-1:0] right_start;
        logic [LEN_W-1:0]     right_len;

        assign valid = (COUNT_W'(i) < n_reg);

        if (i == 0)
        begin : g_first
            // the head cell never takes from the left; it takes the new block
            assign le_left    = 1'b1;
            assign left_start = addr_reg;
            assign left_len   = size_reg;
        end
        else
        begin : g_mid_l
            assign le_left    = flags[i-1].le;
            assign left_start = c_start[i-1];
            assign left_len   = c_len[i-1];
        end

        if (i == ENTRIES - 1)
        begin : g_last
            assign le_right    = 1'b0;
            assign right_start = '0;
            assign right_len   = '0;
        end
        else
        begin : g_mid_r
            assign le_right    = flags[i+1].le;
            assign right_start = c_start[i+1];
            assign right_len   = c_len[i+1];
        end

        flic_cell #(
            .ADDR_BITS (ADDR_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .valid       (valid),
            .le_left     (le_left),
            .le_right    (le_right),
            .addr        (addr_reg),
            .end_new     (end_new),
            .hdr         (hdr_reg),
            .new_len     (new_len),
            .left_start  (left_start),
            .left_len    (left_len),
            .right_start (right_start),
            .right_len   (right_len),
            .flags       (flags[i]),
            .start       (c_start[i]),
            .len         (c_len[i])
        );
    end

    // gather the neighbour extents and the adjacency hits; at most one cell
    // claims each role, so an and-or select is enough
    always_comb
    begin
        any_prev_hit    = 1'b0;
        any_next_hit    = 1'b0;
        prev_start_next = '0;
        prev_len_next   = '0;
        next_len_next   = '0;
        for (int k = 0; k < ENTRIES; k++)
        begin
            any_prev_hit    = any_prev_hit | flags[k].prev_hit;
            any_next_hit    = any_next_hit | flags[k].next_hit;
            prev_start_next = prev_start_next | ({ADDR_BITS{flags[k].prev_sel}} & c_start[k]);
            prev_len_next   = prev_len_next | ({LEN_W{flags[k].prev_sel}} & c_len[k]);
            next_len_next   = next_len_next | ({LEN_W{flags[k].next_sel}} & c_len[k]);
        end
    end

    // choose what the update cycle does
    always_comb
    begin
        if (addr_reg == '0)
        begin
            op_next     = flic_pkg::OP_HOLD;
            status_next = flic_pkg::ST_NULL;
        end
        else if (any_prev_hit && any_next_hit)
        begin
            op_next     = flic_pkg::OP_BOTH;
            status_next = flic_pkg::ST_BOTH;
        end
        else if (any_prev_hit)
        begin
            op_next     = flic_pkg::OP_PREV;
            status_next = flic_pkg::ST_PREV;
        end
        else if (any_next_hit)
        begin
            op_next     = flic_pkg::OP_NEXT;
            status_next = flic_pkg::ST_NEXT;
        end
        else if (n_reg >= COUNT_W'(ENTRIES))
        begin
            // no room and nothing to merge with: the block is dropped
            op_next     = flic_pkg::OP_HOLD;
            status_next = flic_pkg::ST_FULL;
        end
        else
        begin
            op_next     = flic_pkg::OP_INS;
            status_next = flic_pkg::ST_INSERTED;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CMP)
        begin
            op_reg         <= op_next;
            status_reg     <= status_next;
            prev_start_reg <= prev_start_next;
            prev_len_reg   <= prev_len_next;
            next_len_reg   <= next_len_next;
        end
    end

    // ------------------------------------------------------------------
    // update cycle: merged length with saturation, new count, result beat
    // ------------------------------------------------------------------
    assign add_prev = (op_reg == flic_pkg::OP_BOTH) || (op_reg == flic_pkg::OP_PREV);
    assign add_next = (op_reg == flic_pkg::OP_BOTH) || (op_reg == flic_pkg::OP_NEXT);

    always_comb
    begin
        merge_sum = MSUM_W'(size_reg)
                  + (add_prev ? MSUM_W'(prev_len_reg) : MSUM_W'(0))
                  + (add_next ? MSUM_W'(next_len_reg) : MSUM_W'(0))
                  + (add_prev ? MSUM_W'(hdr_reg) : MSUM_W'(0))
                  + (add_next ? MSUM_W'(hdr_reg) : MSUM_W'(0));
        new_len   = (merge_sum[MSUM_W-1:LEN_W] != '0) ? '1 : merge_sum[LEN_W-1:0];
    end

    always_comb
    begin
        n_next   = n_reg;
        res_addr = addr_reg;
        res_size = new_len;
        case (status_reg)
            flic_pkg::ST_BOTH:
            begin
                n_next   = n_reg - COUNT_W'(1);
                res_addr = prev_start_reg;
            end
            flic_pkg::ST_PREV:
            begin
                res_addr = prev_start_reg;
            end
            flic_pkg::ST_INSERTED:
            begin
                n_next = n_reg + COUNT_W'(1);
            end
            flic_pkg::ST_NULL:
            begin
                res_addr = '0;
                res_size = '0;
            end
            default:
            begin
                n_next = n_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else if (commit)
        begin
            n_reg        <= n_next;
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            m_tdata_reg <= {7'd0, 6'(n_next), res_size, 32'(res_addr), status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

@@ design/flic_checker.sv @@
// port-level checks of the free list core, bound to the top level
// depends on flic_pkg and free_list_insert_coalesce_core
`default_nettype none

module flic_checker #(
    parameter int ENTRIES = 32
) (
    input wire        clk,
    input wire        rst_n,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [79:0] m_tdata
);

    // status stays within the defined codes
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] <= flic_pkg::ST_FULL))
        else $error("status code out of range");

    // the table never reports more extents than it holds
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (int'(m_tdata[72:67]) <= ENTRIES) || (ENTRIES > 63))
        else $error("entry count beyond table size");

    // a rejected null block reports an empty extent
    a_null_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[2:0] == flic_pkg::ST_NULL)) |->
        ((m_tdata[34:3] == 32'd0) && (m_tdata[66:35] == 32'd0)))
        else $error("null reject with non-zero extent");

    // the compare cycle always follows an accepted beat
    a_cmp_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("beat taken during compare cycle");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");

endmodule

bind free_list_insert_coalesce_core flic_checker #(
    .ENTRIES (ENTRIES)
) u_flic_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
